/* rtl/r2e_pkg.sv */
`timescale 1ns / 1ps
package r2e_pkg;

  // Fixed-point constants (angles in Q3.13 and Q24, matrix elements in Q2.14).
  localparam int ONE_Q14     = 16384;
  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int PI_Q24      = 52707179;

  // Datapath widths.
  localparam int OP_W     = 18;  // CORDIC operand width before scaling
  localparam int XY_W     = 28;  // CORDIC x/y working width
  localparam int Z_W      = 28;  // CORDIC angle accumulator width
  localparam int TAB_LEN  = 24;  // entries in the arctangent table
  localparam int SQ_IN_W  = 33;  // radicand width, up to 2^32
  localparam int SQ_OUT_W = 17;  // root width, up to 2^16
  localparam int SQ_STEPS = 17;  // one root bit per stage
  localparam int REM_W    = 35;  // square root remainder width

  typedef logic signed [Z_W-1:0]  z_t;
  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [OP_W-1:0] op_t;

  // round(atan(2^-i) * 2^24)
  localparam z_t ATAN_TAB [TAB_LEN] = '{
    z_t'(13176795), z_t'(7778716), z_t'(4110060), z_t'(2086331),
    z_t'(1047214),  z_t'(524117),  z_t'(262123),  z_t'(131069),
    z_t'(65536),    z_t'(32768),   z_t'(16384),   z_t'(8192),
    z_t'(4096),     z_t'(2048),    z_t'(1024),    z_t'(512),
    z_t'(256),      z_t'(128),     z_t'(64),      z_t'(32),
    z_t'(16),       z_t'(8),       z_t'(4),       z_t'(2)
  };

  // Gimbal lock flags.
  typedef struct packed {
    logic pos;  // m31 is +1.0 or above
    logic neg;  // m31 is -1.0 or below
  } lock_t;

  // Data carried alongside the square root.
  typedef struct packed {
    lock_t              lock;
    logic signed [15:0] s;
    logic signed [15:0] yaw_y;
    logic signed [15:0] yaw_x;
    logic signed [16:0] roll_y;
    logic signed [16:0] roll_x;
  } side_t;

endpackage

/* rtl/r2e_ifs.sv */
`timescale 1ns / 1ps
// Matrix input channel.
interface r2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m13;
  logic signed [15:0] m21;
  logic signed [15:0] m31;
  logic signed [15:0] m32;
  logic signed [15:0] m33;

  modport source (output valid, m11, m12, m13, m21, m31, m32, m33, input ready);
  modport sink   (input valid, m11, m12, m13, m21, m31, m32, m33, output ready);
endinterface

// Euler angle result channel.
interface r2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] roll_angle;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

/* rtl/r2e_delay.sv */
`timescale 1ns / 1ps
module r2e_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // Shift line that advances with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

/* rtl/r2e_isqrt.sv */
`timescale 1ns / 1ps
module r2e_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [r2e_pkg::SQ_IN_W-1:0]  radicand,
  output logic [r2e_pkg::SQ_OUT_W-1:0] root
);

  localparam int RW = r2e_pkg::REM_W;
  localparam int OW = r2e_pkg::SQ_OUT_W;
  localparam int NS = r2e_pkg::SQ_STEPS;

  logic [RW-1:0] rem_r  [NS];
  logic [OW-1:0] root_r [NS];

  // One root bit per stage, most significant first.
  for (genvar g = 0; g < NS; g++) begin : g_step
    localparam int K = NS - 1 - g;
    logic [RW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [RW-1:0] trial;

    if (g == 0) begin : g_first
      assign rem_in  = RW'(radicand);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    // Trial subtrahend (2*root + 2^k) * 2^k.
    assign trial = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[g]  <= rem_in - trial;
          root_r[g] <= root_in | (OW'(1) << K);
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in;
        end
      end
    end
  end

  assign root = root_r[NS-1];

endmodule

/* rtl/r2e_cordic.sv */
`timescale 1ns / 1ps
module r2e_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               en,
  input  r2e_pkg::op_t       y_in,
  input  r2e_pkg::op_t       x_in,
  output logic signed [15:0] angle
);

  localparam r2e_pkg::z_t PI_Z  = r2e_pkg::z_t'(r2e_pkg::PI_Q24);
  localparam r2e_pkg::z_t PI_HI = r2e_pkg::z_t'(r2e_pkg::PI_Q13);
  localparam r2e_pkg::z_t PI_LO = -r2e_pkg::z_t'(r2e_pkg::PI_Q13);

  r2e_pkg::xy_t x_r    [STAGES+1];
  r2e_pkg::xy_t y_r    [STAGES+1];
  r2e_pkg::z_t  z_r    [STAGES+1];
  logic         zero_r [STAGES+1];
  logic signed [15:0] angle_r;

  r2e_pkg::xy_t x_sc, y_sc;
  r2e_pkg::z_t  z_rnd;

  // Prologue: scale by 256 and fold the left half plane onto the right.
  assign x_sc = r2e_pkg::xy_t'(x_in) <<< 8;
  assign y_sc = r2e_pkg::xy_t'(y_in) <<< 8;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[r2e_pkg::OP_W-1]) begin
        x_r[0] <= -x_sc;
        y_r[0] <= -y_sc;
        z_r[0] <= y_in[r2e_pkg::OP_W-1] ? -PI_Z : PI_Z;
      end else begin
        x_r[0] <= x_sc;
        y_r[0] <= y_sc;
        z_r[0] <= '0;
      end
    end
  end

  // Vectoring iterations, one per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    r2e_pkg::xy_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][r2e_pkg::XY_W-1]) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + r2e_pkg::ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - r2e_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  // Round to Q3.13 and saturate to plus or minus pi.
  assign z_rnd = (z_r[STAGES] + r2e_pkg::z_t'(1024)) >>> 11;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[STAGES]) begin
        angle_r <= '0;
      end else if (z_rnd > PI_HI) begin
        angle_r <= PI_HI[15:0];
      end else if (z_rnd < PI_LO) begin
        angle_r <= PI_LO[15:0];
      end else begin
        angle_r <= z_rnd[15:0];
      end
    end
  end

  assign angle = angle_r;

endmodule

/* rtl/rotation_matrix_to_euler.sv */
`timescale 1ns / 1ps
// Pipeline stages: input stage, 17 square root stages, CORDIC_STAGES + 2
// CORDIC stages, output register.
// Throughput: one matrix per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset: synchronous, active low; clears the valid bits of every stage.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  r2e_in_if.sink           in_bus,
  r2e_out_if.source        out_bus
);

  localparam int LAT    = r2e_pkg::SQ_STEPS + CORDIC_STAGES + 4;
  localparam int CO_LAT = CORDIC_STAGES + 2;

  logic               en;
  logic [LAT-1:0]     vld_r;

  logic signed [15:0] s_cl;
  logic signed [31:0] sq;
  logic signed [29:0] diff;
  r2e_pkg::side_t     side_nxt, side_r, side_d;
  logic [r2e_pkg::SQ_IN_W-1:0]  c_r;
  logic [r2e_pkg::SQ_OUT_W-1:0] root;

  logic signed [15:0] asin_a, yaw_a, roll_a;
  r2e_pkg::lock_t     lock_d;

  logic signed [15:0] yaw_r, roll_r;
  logic signed [14:0] pitch_r;
  logic signed [15:0] pitch_nxt;

  // The pipeline moves unless the output holds an untaken beat.
  assign en           = !vld_r[LAT-1] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_bus.valid};
    end
  end

  // Input stage: clamp m31, pick the operands, form the cosine radicand.
  always_comb begin
    if (in_bus.m31 > 16'(r2e_pkg::ONE_Q14)) begin
      s_cl = 16'(r2e_pkg::ONE_Q14);
    end else if (in_bus.m31 < -16'sd16384) begin
      s_cl = -16'sd16384;
    end else begin
      s_cl = in_bus.m31;
    end
    sq   = s_cl * s_cl;
    diff = 30'sd268435456 - 30'(sq);

    side_nxt.lock.pos = (s_cl == 16'sd16384);
    side_nxt.lock.neg = (s_cl == -16'sd16384);
    side_nxt.s        = s_cl;
    side_nxt.yaw_y    = in_bus.m21;
    side_nxt.yaw_x    = in_bus.m11;
    if (side_nxt.lock.pos) begin
      side_nxt.roll_y = -17'(in_bus.m12);
      side_nxt.roll_x = -17'(in_bus.m13);
    end else if (side_nxt.lock.neg) begin
      side_nxt.roll_y = 17'(in_bus.m12);
      side_nxt.roll_x = 17'(in_bus.m13);
    end else begin
      side_nxt.roll_y = 17'(in_bus.m32);
      side_nxt.roll_x = 17'(in_bus.m33);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      c_r    <= {diff[28:0], 4'b0000};
    end
  end

  // Cosine of pitch as a floor square root.
  r2e_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (c_r),
    .root     (root)
  );

  r2e_delay #(.WIDTH($bits(r2e_pkg::side_t)), .DEPTH(r2e_pkg::SQ_STEPS)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   (side_r),
    .q   (side_d)
  );

  // Three angle units run side by side.
  r2e_cordic #(.STAGES(CORDIC_STAGES)) u_asin (
    .clk   (clk),
    .en    (en),
    .y_in  (r2e_pkg::op_t'(side_d.s) <<< 2),
    .x_in  (r2e_pkg::op_t'(root)),
    .angle (asin_a)
  );

  r2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (r2e_pkg::op_t'(side_d.yaw_y)),
    .x_in  (r2e_pkg::op_t'(side_d.yaw_x)),
    .angle (yaw_a)
  );

  r2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (r2e_pkg::op_t'(side_d.roll_y)),
    .x_in  (r2e_pkg::op_t'(side_d.roll_x)),
    .angle (roll_a)
  );

  r2e_delay #(.WIDTH($bits(r2e_pkg::lock_t)), .DEPTH(CO_LAT)) u_lock_dly (
    .clk (clk),
    .en  (en),
    .d   (side_d.lock),
    .q   (lock_d)
  );

  // Pitch is minus the arcsine, saturated to a quarter turn.
  always_comb begin
    if (lock_d.pos) begin
      pitch_nxt = -16'sd12868;
    end else if (lock_d.neg) begin
      pitch_nxt = 16'sd12868;
    end else if (asin_a > 16'sd12868) begin
      pitch_nxt = -16'sd12868;
    end else if (asin_a < -16'sd12868) begin
      pitch_nxt = 16'sd12868;
    end else begin
      pitch_nxt = -asin_a;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= (lock_d.pos || lock_d.neg) ? 16'sd0 : yaw_a;
      pitch_r <= pitch_nxt[14:0];
      roll_r  <= roll_a;
    end
  end

  assign out_bus.valid       = vld_r[LAT-1];
  assign out_bus.yaw_angle   = yaw_r;
  assign out_bus.pitch_angle = pitch_r;
  assign out_bus.roll_angle  = roll_r;

  // An accepted beat enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  // Pitch stays within a quarter turn.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.pitch_angle <= 15'sd12868) &&
                      (out_bus.pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  // Yaw and roll stay within a half turn.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.yaw_angle <= 16'sd25736) &&
                      (out_bus.yaw_angle >= -16'sd25736) &&
                      (out_bus.roll_angle <= 16'sd25736) &&
                      (out_bus.roll_angle >= -16'sd25736))
    else $error("yaw or roll out of range");

endmodule

/* bench/rotation_matrix_to_euler_test.sv */
`timescale 1ns / 1ps
module rotation_matrix_to_euler_test;

  localparam int STAGES  = 16;
  localparam int LATENCY = STAGES + 21;
  localparam int N_RAND  = 1850;

  typedef struct {
    logic signed [15:0] m11, m12, m13, m21, m31, m32, m33;
  } matrix_t;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } euler_t;

  // One row of the directed table; known marks a typed-in expectation.
  typedef struct {
    matrix_t m;
    bit      known;
    euler_t  e;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  r2e_in_if  in_bus ();
  r2e_out_if out_bus ();

  rotation_matrix_to_euler #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  euler_t angles_due[$];
  int     mismatches = 0;
  bit     stress_off = 1'b0;
  int     ready_hold = 0;

  // Floor shift of a signed value.
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC arctangent, rounded and saturated to Q3.13.
  function automatic longint vec_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      z = (y >= 0) ? r2e_pkg::PI_Q24 : -r2e_pkg::PI_Q24;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < r2e_pkg::TAB_LEN; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(r2e_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(r2e_pkg::ATAN_TAB[i]);
      end
    end
    z = fshift(z + 1024, 11);
    if (z > r2e_pkg::PI_Q13) z = r2e_pkg::PI_Q13;
    if (z < -r2e_pkg::PI_Q13) z = -r2e_pkg::PI_Q13;
    return z;
  endfunction

  // Floor integer square root.
  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 32;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Euler angles of one matrix.
  function automatic euler_t matrix_angles(matrix_t m);
    euler_t e;
    longint s, yaw, pitch, roll, as;
    s = longint'(m.m31);
    if (s > r2e_pkg::ONE_Q14) s = r2e_pkg::ONE_Q14;
    if (s < -r2e_pkg::ONE_Q14) s = -r2e_pkg::ONE_Q14;
    if (s == r2e_pkg::ONE_Q14) begin
      yaw = 0; pitch = -r2e_pkg::HALF_PI_Q13;
      roll = vec_atan2(-longint'(m.m12), -longint'(m.m13));
    end else if (s == -r2e_pkg::ONE_Q14) begin
      yaw = 0; pitch = r2e_pkg::HALF_PI_Q13;
      roll = vec_atan2(longint'(m.m12), longint'(m.m13));
    end else begin
      as = vec_atan2(s * 4, floor_sqrt((longint'(r2e_pkg::ONE_Q14) * r2e_pkg::ONE_Q14
                                        - s * s) * 16));
      if (as > r2e_pkg::HALF_PI_Q13) as = r2e_pkg::HALF_PI_Q13;
      if (as < -r2e_pkg::HALF_PI_Q13) as = -r2e_pkg::HALF_PI_Q13;
      pitch = -as;
      yaw = vec_atan2(longint'(m.m21), longint'(m.m11));
      roll = vec_atan2(longint'(m.m32), longint'(m.m33));
    end
    e.yaw = yaw[15:0];
    e.pitch = pitch[14:0];
    e.roll = roll[15:0];
    return e;
  endfunction

  function automatic matrix_t mat(int a, int b, int c, int d, int f, int g, int h);
    matrix_t m;
    m.m11 = 16'(a); m.m12 = 16'(b); m.m13 = 16'(c); m.m21 = 16'(d);
    m.m31 = 16'(f); m.m32 = 16'(g); m.m33 = 16'(h);
    return m;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      2: return 16'($urandom_range(0, 5)) - 16'sd2;
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  // Mostly in-range rotation-like elements, some raw noise.
  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.m11 = rand_elem(); m.m12 = rand_elem(); m.m13 = rand_elem();
    m.m21 = rand_elem(); m.m32 = rand_elem(); m.m33 = rand_elem();
    case ($urandom_range(0, 11))
      0: m.m31 = 16'sd16384;
      1: m.m31 = -16'sd16384;
      2: m.m31 = 16'($urandom());
      3: m.m31 = $urandom_range(0, 1) ? 16'sd16383 : -16'sd16383;
      default: m.m31 = rand_elem();
    endcase
    return m;
  endfunction

  // Drive one beat and wait for it to be taken; random gap before it.
  // Valid stays high afterwards so that a following beat can go back to back.
  task automatic send_beat(matrix_t m);
    if (!stress_off && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.m11 <= m.m11; in_bus.m12 <= m.m12; in_bus.m13 <= m.m13;
    in_bus.m21 <= m.m21; in_bus.m31 <= m.m31; in_bus.m32 <= m.m32;
    in_bus.m33 <= m.m33;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_predicted(matrix_t m);
    angles_due.push_back(matrix_angles(m));
    send_beat(m);
  endtask

  // Receiver: random stall bursts, switched off in the last part of the run.
  always @(negedge clk) begin
    if (stress_off || !rst_n) begin
      out_bus.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(0, 7);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    euler_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
      end else begin
        want = angles_due.pop_front();
        if (want.yaw !== out_bus.yaw_angle || want.pitch !== out_bus.pitch_angle ||
            want.roll !== out_bus.roll_angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected y/p/r %0d %0d %0d, got %0d %0d %0d",
                     $time, want.yaw, want.pitch, want.roll, out_bus.yaw_angle,
                     out_bus.pitch_angle, out_bus.roll_angle);
        end
      end
    end
  end

  vector_t table_rows[$];

  task automatic add_row(matrix_t m, bit known, int y, int p, int r);
    vector_t v;
    v.m = m; v.known = known;
    v.e.yaw = 16'(y); v.e.pitch = 15'(p); v.e.roll = 16'(r);
    table_rows.push_back(v);
  endtask

  initial begin
    int wait_cycles;
    in_bus.valid = 1'b0;
    {in_bus.m11, in_bus.m12, in_bus.m13, in_bus.m21} = '0;
    {in_bus.m31, in_bus.m32, in_bus.m33} = '0;
    out_bus.ready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: identity, zero vectors, gimbal lock both ways, clamped m31, extremes.
    add_row(mat(16384, 0, 0, 0, 0, 0, 16384), 1, 0, 0, 0);
    add_row(mat(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
    add_row(mat(0, 0, 0, 0, 16384, 0, 0), 1, 0, -12868, 0);
    add_row(mat(0, 0, 0, 0, -16384, 0, 0), 1, 0, 12868, 0);
    add_row(mat(0, 0, 0, 0, 32767, 0, 0), 1, 0, -12868, 0);
    add_row(mat(0, 0, 0, 0, -32768, 0, 0), 1, 0, 12868, 0);
    add_row(mat(5, 0, 16384, 7, 16384, 9, 3), 0, 0, 0, 0);
    add_row(mat(5, -16384, 16384, 7, -16384, 9, 3), 0, 0, 0, 0);
    add_row(mat(0, 16384, -16384, 0, 16384, 0, 0), 0, 0, 0, 0);
    add_row(mat(-16384, 0, 0, 0, 0, 0, -16384), 0, 0, 0, 0);
    add_row(mat(-16384, 0, 0, -1, 0, -1, -16384), 0, 0, 0, 0);
    add_row(mat(0, 0, 0, 16384, 16383, -16384, 0), 0, 0, 0, 0);
    add_row(mat(0, 0, 0, -16384, -16383, 16384, 0), 0, 0, 0, 0);
    add_row(mat(32767, 32767, 32767, 32767, 1, 32767, 32767), 0, 0, 0, 0);
    add_row(mat(-32768, -32768, -32768, -32768, -1, -32768, -32768), 0, 0, 0, 0);
    add_row(mat(-32768, 32767, -32768, 32767, 8192, 32767, -32768), 0, 0, 0, 0);
    add_row(mat(11585, 0, 0, 11585, -8192, 11585, 11585), 0, 0, 0, 0);

    foreach (table_rows[i]) begin
      if (table_rows[i].known) angles_due.push_back(table_rows[i].e);
      else angles_due.push_back(matrix_angles(table_rows[i].m));
      send_beat(table_rows[i].m);
    end

    // Random matrices; one pause until the pipeline has drained.
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 2) begin
        in_bus.valid <= 1'b0;
        wait (angles_due.size() == 0);
        @(negedge clk);
      end
      if (n == N_RAND - 200) stress_off = 1'b1;
      send_predicted(rand_matrix());
    end
    in_bus.valid <= 1'b0;

    wait_cycles = 0;
    while (angles_due.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("PASS rotation_matrix_to_euler");
    end else begin
      $display("FAIL rotation_matrix_to_euler");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL rotation_matrix_to_euler");
    $finish;
  end

endmodule

/* sim.f */
rtl/r2e_pkg.sv
rtl/r2e_ifs.sv
rtl/r2e_delay.sv
rtl/r2e_isqrt.sv
rtl/r2e_cordic.sv
rtl/rotation_matrix_to_euler.sv
bench/rotation_matrix_to_euler_test.sv
